/* rtl/rofg_pkg.sv */
// ----------------------------------------------------------------------------
// rofg_pkg: shared types and constants
// Payload structs, register indexes, command and status bundles for the
// order-flow generator.
// ----------------------------------------------------------------------------
package rofg_pkg;

    localparam int MaxActive = 256;
    localparam int IdxW      = $clog2(MaxActive);
    localparam int CntW      = $clog2(MaxActive + 1);

    localparam logic [2:0] RegSeed      = 3'd0;
    localparam logic [2:0] RegCancelThr = 3'd1;
    localparam logic [2:0] RegModifyThr = 3'd2;
    localparam logic [2:0] RegMidPrice  = 3'd3;
    localparam logic [2:0] RegSpread    = 3'd4;
    localparam logic [2:0] RegMinQty    = 3'd5;
    localparam logic [2:0] RegMaxQty    = 3'd6;
    localparam logic [2:0] RegNone      = 3'd7;

    localparam logic [1:0] KindRequest = 2'd0;
    localparam logic [1:0] KindAdd     = 2'd1;
    localparam logic [1:0] KindRemove  = 2'd2;
    localparam logic [1:0] KindUnused  = 2'd3;

    localparam logic [1:0] ActNew    = 2'd0;
    localparam logic [1:0] ActCancel = 2'd1;
    localparam logic [1:0] ActModify = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] order_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         action;
        logic               side;
        logic [31:0]        target_id;
        logic signed [31:0] price;
        logic [19:0]        quantity;
    } out_item_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_item;    // capture input item
        logic draw;         // step generator
        logic take_roll;    // classify the roll just drawn
        logic add_id;       // append id
        logic search_init;  // start removal search at top
        logic search_step;  // read one slot, move down
        logic swap_rd;      // read last entry
        logic swap_wr;      // write last entry into hit slot
        logic pick_start;   // start index modulo
        logic pick_rd;      // read chosen slot
        logic pick_take;    // latch chosen id
        logic side_take;
        logic price_start;
        logic price_take;
        logic qty_start;
        logic qty_take;
        logic new_take;     // target = next id, bump it
        logic out_load;     // result into output register
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       is_cancel;
        logic       is_modify;
        logic       search_done;
        logic       search_hit;
        logic       div_busy;
        logic       out_full;
    } sts_t;

endpackage

/* rtl/rofg_mod.sv */
// ----------------------------------------------------------------------------
// rofg_mod: sequential 32-bit remainder unit
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rofg_mod
    import rofg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] remainder
);
    logic [32:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    always_comb begin
        shifted  = {rem_reg[31:0], quo_reg[31]};
        diff     = shifted - {1'b0, dvs_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = 6'd32;
        end else if (cnt_reg != 6'd0) begin
            if (!diff[32]) begin
                rem_next = diff;
            end else begin
                rem_next = shifted;
            end
            quo_next = {quo_reg[30:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = (cnt_reg != 6'd0);
    assign remainder = rem_reg[31:0];
endmodule

/* rtl/rofg_datapath.sv */
// ----------------------------------------------------------------------------
// rofg_datapath: generator, id set and result assembly
// Holds the xorshift state, the active id memory, the config registers,
// one shared remainder unit and the output register.
// ----------------------------------------------------------------------------
module rofg_datapath
    import rofg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_index,
    input  logic [31:0] cfg_wr_data,
    input  in_item_t    item,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        out_ready,
    output out_item_t   out_item
);
    logic [31:0] cthr_reg, mthr_reg;
    logic [29:0] mid_reg;
    logic [19:0] spread_reg, minq_reg, maxq_reg;

    logic [31:0] rng_reg, rng_next;
    logic [31:0] draw_val;
    logic [CntW-1:0] count_reg, count_next;
    logic [31:0] next_id_reg, next_id_next;
    logic [1:0]  kind_reg;
    logic [31:0] id_reg;

    logic [31:0] mem [MaxActive];
    logic [31:0] rd_data_reg;
    logic [IdxW-1:0] rd_addr;
    logic        rd_en;
    logic [IdxW-1:0] wr_addr;
    logic [31:0] wr_data;
    logic        wr_en;

    logic [CntW-1:0] srch_reg, srch_next;
    logic [IdxW-1:0] hit_idx_reg;
    logic        done_reg, hit_reg;
    logic        cmp_pending_reg;

    logic        cancel_reg, modify_reg;
    logic        div_start;
    logic [31:0] div_a, div_b;
    logic        div_busy;
    logic [31:0] div_rem;

    out_item_t   res_reg;
    out_item_t   out_reg;
    logic        out_full_reg;
    logic [32:0] both;
    logic [31:0] qspan;

    // Configuration registers. The seed goes straight into the generator.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cthr_reg   <= '0;
            mthr_reg   <= '0;
            mid_reg    <= 30'd10000;
            spread_reg <= 20'd10;
            minq_reg   <= 20'd1;
            maxq_reg   <= 20'd100;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                RegSeed:      ;
                RegCancelThr: cthr_reg   <= cfg_wr_data;
                RegModifyThr: mthr_reg   <= cfg_wr_data;
                RegMidPrice:  mid_reg    <= cfg_wr_data[29:0];
                RegSpread:    spread_reg <= cfg_wr_data[19:0];
                RegMinQty:    minq_reg   <= cfg_wr_data[19:0];
                RegMaxQty:    maxq_reg   <= cfg_wr_data[19:0];
                default: ;
            endcase
        end
    end

    // Xorshift32 step.
    always_comb begin
        draw_val = rng_reg ^ (rng_reg << 13);
        draw_val = draw_val ^ (draw_val >> 17);
        draw_val = draw_val ^ (draw_val << 5);
        rng_next = rng_reg;
        if (cfg_wr_en && cfg_wr_index == RegSeed) begin
            rng_next = cfg_wr_data;
        end else if (cmd.draw) begin
            rng_next = draw_val;
        end
    end

    // Memory port control. An add to a full set writes nothing.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = id_reg;
        if (cmd.add_id && count_reg != CntW'(MaxActive)) begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IdxW-1:0];
        end
        if (cmd.search_step) begin
            rd_en   = 1'b1;
            rd_addr = srch_next[IdxW-1:0];
        end
        if (cmd.swap_rd) begin
            rd_en   = 1'b1;
            rd_addr = count_next[IdxW-1:0];
        end
        if (cmd.swap_wr) begin
            wr_en   = 1'b1;
            wr_addr = hit_idx_reg;
            wr_data = rd_data_reg;
        end
        if (cmd.pick_rd) begin
            rd_en   = 1'b1;
            rd_addr = div_rem[IdxW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Search walks down from the top; a read issued one cycle is compared
    // the next. srch_next is the slot read this cycle.
    always_comb begin
        srch_next  = srch_reg;
        count_next = count_reg;
        if (cmd.search_step) begin
            srch_next = srch_reg - CntW'(1);
        end
        if (cmd.add_id && count_reg != CntW'(MaxActive)) begin
            count_next = count_reg + CntW'(1);
        end
        if (cmd.swap_rd) begin
            count_next = count_reg - CntW'(1);
        end
        next_id_next = next_id_reg;
        if (cmd.new_take) begin
            next_id_next = next_id_reg + 32'd1;
        end
    end

    assign both = {1'b0, cthr_reg} + {1'b0, mthr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rng_reg         <= 32'd1;
            count_reg       <= '0;
            next_id_reg     <= 32'd1;
            done_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            cmp_pending_reg <= 1'b0;
            out_full_reg    <= 1'b0;
        end else begin
            rng_reg     <= rng_next;
            count_reg   <= count_next;
            next_id_reg <= next_id_next;
            if (cmd.search_init) begin
                done_reg        <= (count_reg == '0);
                hit_reg         <= 1'b0;
                cmp_pending_reg <= 1'b0;
            end else if (cmd.search_step || cmp_pending_reg) begin
                cmp_pending_reg <= cmd.search_step;
                if (cmp_pending_reg && rd_data_reg == id_reg) begin
                    hit_reg  <= 1'b1;
                    done_reg <= 1'b1;
                end else if (cmp_pending_reg && srch_reg == '0) begin
                    // Slot zero compared without a match: the id is unknown.
                    done_reg <= 1'b1;
                end
            end
            if (cmd.out_load) begin
                out_full_reg <= 1'b1;
            end else if (out_ready) begin
                out_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg <= item.kind;
            id_reg   <= item.order_id;
        end
        if (cmd.search_init) begin
            srch_reg <= count_reg;
        end else begin
            srch_reg <= srch_next;
        end
        if (cmd.search_step) begin
            hit_idx_reg <= srch_next[IdxW-1:0];
        end
        if (cmd.take_roll) begin
            cancel_reg <= ({1'b0, draw_val} < {1'b0, cthr_reg}) && (count_reg != '0);
            modify_reg <= ({1'b0, draw_val} < both) && (count_reg != '0);
        end
        if (cmd.take_roll) begin
            res_reg <= '0;
        end
        if (cmd.pick_take) begin
            res_reg.target_id <= rd_data_reg;
            res_reg.action    <= cancel_reg ? ActCancel : ActModify;
        end
        if (cmd.new_take) begin
            res_reg.target_id <= next_id_reg;
            res_reg.action    <= ActNew;
        end
        if (cmd.side_take) begin
            res_reg.side <= ~draw_val[0];
        end
        if (cmd.price_take) begin
            res_reg.price <= $signed({2'b00, mid_reg} + div_rem - {12'd0, spread_reg});
        end
        if (cmd.qty_take) begin
            if (minq_reg > maxq_reg) begin
                res_reg.quantity <= minq_reg;
            end else begin
                res_reg.quantity <= minq_reg + div_rem[19:0];
            end
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    // Shared remainder unit operand selection.
    assign qspan = {12'd0, maxq_reg} - {12'd0, minq_reg} + 32'd1;
    always_comb begin
        div_start = cmd.pick_start | cmd.price_start | cmd.qty_start;
        div_a     = draw_val;
        div_b     = {{(32-CntW){1'b0}}, count_reg};
        if (cmd.price_start) begin
            div_b = {11'd0, spread_reg, 1'b0} + 32'd1;
        end else if (cmd.qty_start) begin
            div_b = qspan;
        end
    end

    rofg_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .busy      (div_busy),
        .remainder (div_rem)
    );

    assign sts.kind        = kind_reg;
    assign sts.is_cancel   = cancel_reg;
    assign sts.is_modify   = modify_reg;
    assign sts.search_done = done_reg;
    assign sts.search_hit  = hit_reg;
    assign sts.div_busy    = div_busy;
    assign sts.out_full    = out_full_reg;
    assign out_item        = out_reg;
endmodule

/* rtl/rofg_ctrl.sv */
// ----------------------------------------------------------------------------
// rofg_ctrl: sequencing state machine
// Steps each item through add, removal search or the draw sequence.
// ----------------------------------------------------------------------------
module rofg_ctrl
    import rofg_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    typedef enum logic [14:0] {
        StIdle    = 15'b000000000000001,
        StDecode  = 15'b000000000000010,
        StSearch  = 15'b000000000000100,
        StSwapRd  = 15'b000000000001000,
        StSwapWr  = 15'b000000000010000,
        StPick    = 15'b000000000100000,
        StPickRd  = 15'b000000001000000,
        StSide    = 15'b000000010000000,
        StPrice   = 15'b000000100000000,
        StQty     = 15'b000001000000000,
        StQtyDone = 15'b000010000000000,
        StOut     = 15'b000100000000000,
        StRoll    = 15'b001000000000000,
        StCompare = 15'b010000000000000,
        StPickTk  = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            StIdle: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = StDecode;
                end
            end
            StDecode: begin
                unique case (sts.kind)
                    KindAdd: begin
                        cmd.add_id = 1'b1;
                        state_next = StIdle;
                    end
                    KindRemove: begin
                        cmd.search_init = 1'b1;
                        state_next      = StSearch;
                    end
                    KindRequest: state_next = StRoll;
                    default:     state_next = StIdle;
                endcase
            end
            StRoll: begin
                if (!sts.out_full) begin
                    cmd.draw      = 1'b1;
                    cmd.take_roll = 1'b1;
                    state_next    = StPick;
                end
            end
            StSearch: begin
                if (sts.search_done) begin
                    state_next = sts.search_hit ? StSwapRd : StIdle;
                end else begin
                    // Read one slot; the compare happens in the next cycle.
                    cmd.search_step = 1'b1;
                    state_next      = StCompare;
                end
            end
            StCompare: begin
                state_next = StSearch;
            end
            StSwapRd: begin
                cmd.swap_rd = 1'b1;
                state_next  = StSwapWr;
            end
            StSwapWr: begin
                cmd.swap_wr = 1'b1;
                state_next  = StIdle;
            end
            StPick: begin
                if (sts.is_cancel || sts.is_modify) begin
                    cmd.draw       = 1'b1;
                    cmd.pick_start = 1'b1;
                    state_next     = StPickRd;
                end else begin
                    cmd.new_take = 1'b1;
                    state_next   = StSide;
                end
            end
            StPickRd: begin
                if (!sts.div_busy) begin
                    cmd.pick_rd = 1'b1;
                    state_next  = StPickTk;
                end
            end
            StPickTk: begin
                cmd.pick_take = 1'b1;
                state_next    = sts.is_cancel ? StOut : StSide;
            end
            StSide: begin
                cmd.draw      = 1'b1;
                cmd.side_take = 1'b1;
                state_next    = StPrice;
            end
            StPrice: begin
                cmd.draw        = 1'b1;
                cmd.price_start = 1'b1;
                state_next      = StQty;
            end
            StQty: begin
                if (!sts.div_busy) begin
                    cmd.price_take = 1'b1;
                    cmd.draw       = 1'b1;
                    cmd.qty_start  = 1'b1;
                    state_next     = StQtyDone;
                end
            end
            StQtyDone: begin
                if (!sts.div_busy) begin
                    cmd.qty_take = 1'b1;
                    state_next   = StOut;
                end
            end
            StOut: begin
                cmd.out_load = 1'b1;
                state_next   = StIdle;
            end
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= StIdle;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

/* rtl/random_order_flow_generator_core.sv */
// ----------------------------------------------------------------------------
// random_order_flow_generator_core: synthetic order-flow source
// Xorshift32-driven generator of new, cancel and modify orders over a
// set of up to 256 active ids kept in on-chip memory.
// ----------------------------------------------------------------------------
// An add beat is accepted and then appended to the set in the decode state.
// A remove beat searches the active set from the highest slot down, reading
// each slot and comparing it in the next state, and on a hit moves the last
// entry into the freed slot with one read and one write. A request beat
// waits on the shared remainder unit for its slot index, price and quantity;
// a cancel draws a roll and an index, a new order a roll, a side, a price
// and a quantity, and a modify all of these, up to five generator draws.
// The finished result sits in an output register, so the next beat is taken
// while it waits; a further request stalls before its first draw until the
// register is free. Configuration must be written through the plain write
// port between beats, while nothing is in flight; the block itself does not
// enforce this. A seed write also reloads the generator at once.
module random_order_flow_generator_core
    import rofg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_index,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);
    cmd_t cmd;
    sts_t sts;

    // The sequencer owns all ordering; the datapath only executes commands.
    rofg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rofg_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .item         (s_data),
        .cmd          (cmd),
        .sts          (sts),
        .out_ready    (m_ready),
        .out_item     (m_data)
    );

    assign m_valid = sts.out_full;

    // A result is never loaded over one that has not been taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !sts.out_full || m_ready)
        else $error("result register overwritten");

    // An accepted beat always starts the decode step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while busy");

    // A result is only produced for a request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.kind == KindRequest)
        else $error("result for non-request beat");
endmodule
